FILE: hdl/cstrip_pkg.sv
// ----------------------------------------------------------------------------
// cstrip_pkg
// Shared types, character codes and scan helpers for the C comment stripper.
// ----------------------------------------------------------------------------
package cstrip_pkg;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Scanner modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_DQUOTE = 3'd1;
    localparam logic [2:0] MODE_SQUOTE = 3'd2;
    localparam logic [2:0] MODE_LINE   = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;

    // Run capacity in bytes; one source byte releases at most four
    localparam int MAX_RUN = 5;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);

    // Run queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] clean_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_done;
        logic       unterminated_comment;
    } t_out_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       esc;
        logic       slash;
        logic       star;
    } t_scan_state;

    typedef struct packed {
        t_scan_state st;
        logic [1:0]  n;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } t_scan_out;

    // All output bytes caused by one source byte
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_W-1:0]        cnt;
        logic                    last;
        logic                    unterm;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One byte of spliced text through the comment/literal scanner
    function automatic t_scan_out scan_byte(t_scan_state s, logic [7:0] c);
        t_scan_out  o;
        logic [7:0] qch;
        o     = '0;
        o.st  = s;
        qch   = (s.mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
        case (s.mode)
            MODE_DQUOTE, MODE_SQUOTE: begin
                o.n  = 2'd1;
                o.b0 = c;
                if (s.esc) begin
                    o.st.esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    o.st.esc = 1'b1;
                end else if (c == qch) begin
                    o.st.mode = MODE_NORMAL;
                end
            end
            MODE_LINE: begin
                if (c == CH_NL) begin
                    o.st.mode = MODE_NORMAL;
                    o.n       = 2'd1;
                    o.b0      = CH_NL;
                end
            end
            MODE_BLOCK: begin
                if (s.star && (c == CH_SLASH)) begin
                    o.st.mode = MODE_NORMAL;
                    o.st.star = 1'b0;
                end else begin
                    o.st.star = (c == CH_STAR);
                    if (c == CH_NL) begin
                        o.n  = 2'd1;
                        o.b0 = CH_NL;
                    end
                end
            end
            default: begin
                if (s.slash && (c == CH_SLASH)) begin
                    o.st.slash = 1'b0;
                    o.st.mode  = MODE_LINE;
                    o.n        = 2'd1;
                    o.b0       = CH_SPACE;
                end else if (s.slash && (c == CH_STAR)) begin
                    o.st.slash = 1'b0;
                    o.st.mode  = MODE_BLOCK;
                    o.st.star  = 1'b0;
                    o.n        = 2'd1;
                    o.b0       = CH_SPACE;
                end else if (c == CH_SLASH) begin
                    o.st.slash = 1'b1;
                end else begin
                    o.st.slash = 1'b0;
                    if (s.slash) begin
                        o.n  = 2'd2;
                        o.b0 = CH_SLASH;
                        o.b1 = c;
                    end else begin
                        o.n  = 2'd1;
                        o.b0 = c;
                    end
                    if (c == CH_DQUOTE) begin
                        o.st.mode = MODE_DQUOTE;
                        o.st.esc  = 1'b0;
                    end else if (c == CH_SQUOTE) begin
                        o.st.mode = MODE_SQUOTE;
                        o.st.esc  = 1'b0;
                    end
                end
            end
        endcase
        return o;
    endfunction

    // Append one byte to a run
    function automatic t_run run_add(t_run r, logic [7:0] b);
        t_run o;
        o = r;
        if (r.cnt < RUN_W'(MAX_RUN)) begin
            o.bytes[r.cnt] = b;
            o.cnt          = RUN_W'(r.cnt + RUN_W'(1));
        end
        return o;
    endfunction

    // Append whatever a scan step released
    function automatic t_run run_push(t_run r, t_scan_out so);
        t_run o;
        o = r;
        if (so.n != 2'd0) begin
            o = run_add(o, so.b0);
        end
        if (so.n == 2'd2) begin
            o = run_add(o, so.b1);
        end
        return o;
    endfunction

endpackage

FILE: hdl/cstrip_front.sv
// ----------------------------------------------------------------------------
// cstrip_front
// Splice removal and scanning; turns each source byte into a run of bytes.
// ----------------------------------------------------------------------------
module cstrip_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cstrip_pkg::t_in_item i_in_data,
    output logic                o_in_stall,
    input  cstrip_pkg::t_q_status i_q_status,
    output logic                o_push,
    output cstrip_pkg::t_run    o_push_run
);

    cstrip_pkg::t_scan_state r_scan, n_scan;
    logic                    r_bs_held, n_bs_held;
    logic                    r_cr_held, n_cr_held;

    cstrip_pkg::t_scan_state s;
    cstrip_pkg::t_scan_out   so;
    cstrip_pkg::t_run        run;
    logic [7:0]              c;
    logic                    skip;
    logic                    bs;
    logic                    cr;
    logic                    had_cr;
    logic                    accept;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    always_comb begin
        c      = i_in_data.source_byte;
        s      = r_scan;
        bs     = r_bs_held;
        cr     = r_cr_held;
        skip   = 1'b0;
        had_cr = 1'b0;
        so     = '0;
        run    = '0;

        // splice stage
        if (cr) begin
            cr = 1'b0;
            bs = 1'b0;
            if (c == cstrip_pkg::CH_NL) begin
                skip = 1'b1;
            end else begin
                so  = cstrip_pkg::scan_byte(s, cstrip_pkg::CH_BSLASH);
                s   = so.st;
                run = cstrip_pkg::run_push(run, so);
                so  = cstrip_pkg::scan_byte(s, cstrip_pkg::CH_CR);
                s   = so.st;
                run = cstrip_pkg::run_push(run, so);
            end
        end else if (bs) begin
            bs = 1'b0;
            if (c == cstrip_pkg::CH_NL) begin
                skip = 1'b1;
            end else if (c == cstrip_pkg::CH_CR) begin
                bs   = 1'b1;
                cr   = 1'b1;
                skip = 1'b1;
            end else begin
                so  = cstrip_pkg::scan_byte(s, cstrip_pkg::CH_BSLASH);
                s   = so.st;
                run = cstrip_pkg::run_push(run, so);
            end
        end
        if (!skip) begin
            if (c == cstrip_pkg::CH_BSLASH) begin
                bs = 1'b1;
            end else begin
                so  = cstrip_pkg::scan_byte(s, c);
                s   = so.st;
                run = cstrip_pkg::run_push(run, so);
            end
        end

        // end of text: flush held bytes, flag open block comment, clear state
        if (i_in_data.end_of_text) begin
            if (bs) begin
                had_cr = cr;
                bs     = 1'b0;
                cr     = 1'b0;
                so     = cstrip_pkg::scan_byte(s, cstrip_pkg::CH_BSLASH);
                s      = so.st;
                run    = cstrip_pkg::run_push(run, so);
                if (had_cr) begin
                    so  = cstrip_pkg::scan_byte(s, cstrip_pkg::CH_CR);
                    s   = so.st;
                    run = cstrip_pkg::run_push(run, so);
                end
            end
            if (s.slash && (s.mode == cstrip_pkg::MODE_NORMAL)) begin
                s.slash = 1'b0;
                run     = cstrip_pkg::run_add(run, cstrip_pkg::CH_SLASH);
            end
            run.last   = 1'b1;
            run.unterm = (s.mode == cstrip_pkg::MODE_BLOCK);
            s          = '0;
            s.mode     = cstrip_pkg::MODE_NORMAL;
        end

        n_scan    = s;
        n_bs_held = bs;
        n_cr_held = cr;
    end

    assign o_push     = accept && ((run.cnt != '0) || i_in_data.end_of_text);
    assign o_push_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '{mode: cstrip_pkg::MODE_NORMAL, default: '0};
            r_bs_held <= 1'b0;
            r_cr_held <= 1'b0;
        end else if (accept) begin
            r_scan    <= n_scan;
            r_bs_held <= n_bs_held;
            r_cr_held <= n_cr_held;
        end
    end

endmodule

FILE: hdl/cstrip_queue.sv
// ----------------------------------------------------------------------------
// cstrip_queue
// Small FIFO of byte runs between the scanner and the output serializer.
// ----------------------------------------------------------------------------
module cstrip_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cstrip_pkg::t_run      i_push_run,
    input  logic                  i_pop,
    output cstrip_pkg::t_run      o_head,
    output cstrip_pkg::t_q_status o_status
);

    cstrip_pkg::t_run                  r_mem [cstrip_pkg::QDEPTH];
    logic [cstrip_pkg::QPTR_W-1:0]     r_wp, r_rp;
    logic [cstrip_pkg::QCNT_W-1:0]     r_cnt;
    logic                              do_push, do_pop;

    assign o_status.full  = (r_cnt == cstrip_pkg::QCNT_W'(cstrip_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= cstrip_pkg::QPTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= cstrip_pkg::QPTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= cstrip_pkg::QCNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= cstrip_pkg::QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

FILE: hdl/cstrip_back.sv
// ----------------------------------------------------------------------------
// cstrip_back
// Serializes queued runs into single output transactions.
// ----------------------------------------------------------------------------
module cstrip_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cstrip_pkg::t_run      i_head,
    input  cstrip_pkg::t_q_status i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output cstrip_pkg::t_out_item o_out_data,
    input  logic                  i_out_stall
);

    logic                           r_out_valid;
    cstrip_pkg::t_out_item          r_out;
    cstrip_pkg::t_out_item          n_out;
    logic [cstrip_pkg::RUN_W-1:0]   r_idx;
    logic [cstrip_pkg::RUN_W-1:0]   last_idx;
    logic                           load;
    logic                           take;
    logic                           at_end;
    logic                           has_bytes;

    assign load      = !r_out_valid || !i_out_stall;
    assign take      = load && !i_q_status.empty;
    assign has_bytes = (i_head.cnt != '0);
    assign last_idx  = has_bytes ? cstrip_pkg::RUN_W'(i_head.cnt - 1'b1) : '0;
    assign at_end    = (r_idx == last_idx);
    assign o_pop     = take && at_end;

    always_comb begin
        n_out                      = '0;
        n_out.clean_byte           = has_bytes ? i_head.bytes[r_idx] : 8'd0;
        n_out.byte_valid           = has_bytes;
        n_out.run_last             = at_end;
        n_out.text_done            = at_end && i_head.last;
        n_out.unterminated_comment = at_end && i_head.last && i_head.unterm;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load) begin
            r_out_valid <= !i_q_status.empty;
            if (take) begin
                r_idx <= at_end ? '0 : cstrip_pkg::RUN_W'(r_idx + 1'b1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/c_comment_stripper.sv
// Path: each accepted source byte's run is written into the run queue, then its results
//   are loaded from the queue head into the output register while the output is not stalled.
// Throughput: one source byte per cycle while bytes release at most one result and the
//   output is not stalled; a byte releasing more than one result (up to 4) is walked out
//   result by result, and a four-entry run queue absorbs such bursts. Set by the one-result-per-cycle port.
// Reset: synchronous active-low; scanner in normal text, nothing held, queue empty.
// ----------------------------------------------------------------------------
// c_comment_stripper
// C comment and line-splice stripper, one source byte per input transaction.
// ----------------------------------------------------------------------------
module c_comment_stripper (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // source byte transactions
    input  logic                  i_in_valid,
    input  cstrip_pkg::t_in_item  i_in_data,
    output logic                  o_in_stall,
    // cleaned byte transactions
    output logic                  o_out_valid,
    output cstrip_pkg::t_out_item o_out_data,
    input  logic                  i_out_stall
);

    // Front: splice removal plus comment/literal scan. Each accepted byte is
    // fully processed in its cycle and every byte it releases is packed into
    // one run entry. Quiet bytes push nothing; the final byte always pushes,
    // even an empty run, so the end-of-text transaction is produced.
    cstrip_pkg::t_q_status q_status;
    logic                  push;
    cstrip_pkg::t_run      push_run;

    // Back: walks the head run one byte per cycle, while the output is not stalled, into the output register.
    logic                  pop;
    cstrip_pkg::t_run      head;

    cstrip_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_run (push_run)
    );

    // Queue between the two sides: front stalls only when it is full, so
    // an output stall does not reach the input until four runs pile up.
    cstrip_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_run (push_run),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    cstrip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for c_comment_stripper. A short text table hits comment,
// literal and splice corners, then random C-like texts run under four
// sender/receiver idle mixes. Each accepted byte goes through a local
// stripper model and every output transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 2000;  // cycles with no transaction on either side
    localparam int HOLD_OFF_CYCLES = 80;    // long receiver stall, fills the run queue
    localparam int ITEMS_PER_PHASE = 28;
    localparam int DRAIN_CYCLES    = 20;

    // flag nibble of a typed result: {byte_valid, run_last, text_done, unterminated}
    localparam logic [3:0] FL_NONE       = 4'b0000;
    localparam logic [3:0] FL_BYTE       = 4'b1100;
    localparam logic [3:0] FL_DONE       = 4'b1110;
    localparam logic [3:0] FL_UNTERM_END = 4'b0111;

    // idle mix per random phase: none, sender idle, receiver stall, both
    localparam int GAP_PCT   [4] = '{0, 85, 0, 33};
    localparam int STALL_PCT [4] = '{0, 0, 85, 33};

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;       // 1: single result typed in below
        logic [7:0] want_byte;
        logic [3:0] want_flags;
    } t_text_row;

    localparam int DIRECTED_ROWS = 31;

    // Directed text. Untyped rows are checked against the model.
    t_text_row directed_text [DIRECTED_ROWS] = '{
        {8'h01, 1'b0, 1'b1, 8'h01, FL_BYTE},                        // lowest byte
        {8'hFF, 1'b0, 1'b1, 8'hFF, FL_BYTE},                        // highest byte
        {8'h00, 1'b0, 1'b1, 8'h00, FL_BYTE},                        // zero passes as text
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},        // slash held
        {cstrip_pkg::CH_STAR,   1'b0, 1'b1, cstrip_pkg::CH_SPACE, FL_BYTE}, // block opens
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},        // opener star no close
        {cstrip_pkg::CH_NL,     1'b0, 1'b1, cstrip_pkg::CH_NL, FL_BYTE}, // NL kept in block
        {cstrip_pkg::CH_STAR,   1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},        // block closes
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b1, cstrip_pkg::CH_SPACE, FL_BYTE}, // line comment
        {cstrip_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_NL,     1'b0, 1'b0, 8'h00, FL_NONE},        // splice keeps comment
        {cstrip_pkg::CH_NL,     1'b0, 1'b1, cstrip_pkg::CH_NL, FL_BYTE}, // comment ends
        {cstrip_pkg::CH_DQUOTE, 1'b0, 1'b1, cstrip_pkg::CH_DQUOTE, FL_BYTE},
        {cstrip_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_DQUOTE, 1'b0, 1'b0, 8'h00, FL_NONE},        // escaped quote, two bytes
        {cstrip_pkg::CH_DQUOTE, 1'b0, 1'b1, cstrip_pkg::CH_DQUOTE, FL_BYTE}, // string closes
        {cstrip_pkg::CH_SQUOTE, 1'b0, 1'b1, cstrip_pkg::CH_SQUOTE, FL_BYTE},
        {cstrip_pkg::CH_SQUOTE, 1'b0, 1'b0, 8'h00, FL_NONE},        // empty char literal
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_CR,     1'b0, 1'b0, 8'h00, FL_NONE},        // backslash-CR held
        {"q",                   1'b1, 1'b0, 8'h00, FL_NONE},        // releases four bytes
        {cstrip_pkg::CH_SLASH,  1'b0, 1'b0, 8'h00, FL_NONE},
        {cstrip_pkg::CH_STAR,   1'b0, 1'b1, cstrip_pkg::CH_SPACE, FL_BYTE},
        {"z",                   1'b1, 1'b1, 8'h00, FL_UNTERM_END},  // ends inside block
        {cstrip_pkg::CH_BSLASH, 1'b1, 1'b1, cstrip_pkg::CH_BSLASH, FL_DONE}, // held at end
        {cstrip_pkg::CH_DQUOTE, 1'b0, 1'b1, cstrip_pkg::CH_DQUOTE, FL_BYTE},
        {"k",                   1'b1, 1'b1, "k", FL_DONE},          // open literal, no flag
        {cstrip_pkg::CH_SLASH,  1'b1, 1'b1, cstrip_pkg::CH_SLASH, FL_DONE}   // held slash
    };

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    cstrip_pkg::t_in_item  in_item   = '0;
    logic                  in_stall;
    logic                  out_valid;
    cstrip_pkg::t_out_item out_item;
    logic                  out_stall = 1'b0;

    c_comment_stripper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stripper model: splice stage feeding the comment/literal scanner
    // ------------------------------------------------------------------
    logic [2:0] sc_mode   = cstrip_pkg::MODE_NORMAL;
    logic       sc_esc    = 1'b0;
    logic       sc_slash  = 1'b0;
    logic       sc_star   = 1'b0;
    logic       sc_bslash = 1'b0;
    logic       sc_cr     = 1'b0;

    logic [7:0]            released [$];       // bytes released by the current source byte
    cstrip_pkg::t_out_item item_results [$];   // results the current source byte should produce
    cstrip_pkg::t_out_item expected_clean_q [$];

    task automatic clear_scan();
        sc_mode   = cstrip_pkg::MODE_NORMAL;
        sc_esc    = 1'b0;
        sc_slash  = 1'b0;
        sc_star   = 1'b0;
        sc_bslash = 1'b0;
        sc_cr     = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c);
        case (sc_mode)
            cstrip_pkg::MODE_DQUOTE, cstrip_pkg::MODE_SQUOTE: begin
                released.push_back(c);
                if (sc_esc) begin
                    sc_esc = 1'b0;
                end else if (c == cstrip_pkg::CH_BSLASH) begin
                    sc_esc = 1'b1;
                end else if (c == ((sc_mode == cstrip_pkg::MODE_DQUOTE) ?
                                   cstrip_pkg::CH_DQUOTE : cstrip_pkg::CH_SQUOTE)) begin
                    sc_mode = cstrip_pkg::MODE_NORMAL;
                end
            end
            cstrip_pkg::MODE_LINE: begin
                if (c == cstrip_pkg::CH_NL) begin
                    sc_mode = cstrip_pkg::MODE_NORMAL;
                    released.push_back(cstrip_pkg::CH_NL);
                end
            end
            cstrip_pkg::MODE_BLOCK: begin
                if (sc_star && c == cstrip_pkg::CH_SLASH) begin
                    sc_mode = cstrip_pkg::MODE_NORMAL;
                    sc_star = 1'b0;
                end else begin
                    sc_star = (c == cstrip_pkg::CH_STAR);
                    if (c == cstrip_pkg::CH_NL) released.push_back(cstrip_pkg::CH_NL);
                end
            end
            default: begin
                if (sc_slash) begin
                    sc_slash = 1'b0;
                    if (c == cstrip_pkg::CH_SLASH) begin
                        released.push_back(cstrip_pkg::CH_SPACE);
                        sc_mode = cstrip_pkg::MODE_LINE;
                        return;
                    end
                    if (c == cstrip_pkg::CH_STAR) begin
                        released.push_back(cstrip_pkg::CH_SPACE);
                        sc_mode = cstrip_pkg::MODE_BLOCK;
                        sc_star = 1'b0;
                        return;
                    end
                    released.push_back(cstrip_pkg::CH_SLASH);
                end
                if (c == cstrip_pkg::CH_SLASH) begin
                    sc_slash = 1'b1;
                end else begin
                    released.push_back(c);
                    if (c == cstrip_pkg::CH_DQUOTE) begin
                        sc_mode = cstrip_pkg::MODE_DQUOTE;
                        sc_esc  = 1'b0;
                    end else if (c == cstrip_pkg::CH_SQUOTE) begin
                        sc_mode = cstrip_pkg::MODE_SQUOTE;
                        sc_esc  = 1'b0;
                    end
                end
            end
        endcase
    endtask

    task automatic splice_char(input logic [7:0] c);
        if (sc_cr) begin
            sc_cr     = 1'b0;
            sc_bslash = 1'b0;
            if (c == cstrip_pkg::CH_NL) return;
            scan_char(cstrip_pkg::CH_BSLASH);
            scan_char(cstrip_pkg::CH_CR);
        end else if (sc_bslash) begin
            sc_bslash = 1'b0;
            if (c == cstrip_pkg::CH_NL) return;
            if (c == cstrip_pkg::CH_CR) begin
                sc_bslash = 1'b1;
                sc_cr     = 1'b1;
                return;
            end
            scan_char(cstrip_pkg::CH_BSLASH);
        end
        if (c == cstrip_pkg::CH_BSLASH) sc_bslash = 1'b1;
        else scan_char(c);
    endtask

    // Fills item_results with what one accepted source byte must produce
    task automatic predict_item(input cstrip_pkg::t_in_item it);
        logic                  held_cr;
        logic                  unterm;
        cstrip_pkg::t_out_item r;
        released.delete();
        item_results.delete();
        unterm = 1'b0;
        splice_char(it.source_byte);
        if (it.end_of_text) begin
            // flush anything still held, then back to reset state
            if (sc_bslash) begin
                held_cr   = sc_cr;
                sc_bslash = 1'b0;
                sc_cr     = 1'b0;
                scan_char(cstrip_pkg::CH_BSLASH);
                if (held_cr) scan_char(cstrip_pkg::CH_CR);
            end
            if (sc_slash && sc_mode == cstrip_pkg::MODE_NORMAL) begin
                sc_slash = 1'b0;
                released.push_back(cstrip_pkg::CH_SLASH);
            end
            unterm = (sc_mode == cstrip_pkg::MODE_BLOCK);
            clear_scan();
        end
        if (released.size() == 0) begin
            if (it.end_of_text) begin
                // quiet end of text: one marker result with no byte
                r = '0;
                r.run_last = 1'b1;
                r.text_done = 1'b1;
                r.unterminated_comment = unterm;
                item_results.push_back(r);
            end
        end else begin
            foreach (released[k]) begin
                r.clean_byte = released[k];
                r.byte_valid = 1'b1;
                r.run_last = (k == released.size() - 1);
                r.text_done = r.run_last && it.end_of_text;
                r.unterminated_comment = r.text_done && unterm;
                item_results.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Random C-like text
    // ------------------------------------------------------------------
    logic [7:0] text_bytes [$];

    function automatic logic [7:0] letter();
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] comment_char();
        case ($urandom_range(0, 5))
            0:       return cstrip_pkg::CH_STAR;
            1:       return cstrip_pkg::CH_NL;
            2:       return cstrip_pkg::CH_SLASH;
            default: return letter();
        endcase
    endfunction

    task automatic build_text();
        int target;
        int n;
        target = $urandom_range(4, 20);
        text_bytes.delete();
        while (text_bytes.size() < target) begin
            case ($urandom_range(0, 11))
                0, 11: text_bytes.push_back(8'($urandom_range(1, 255)));
                1, 2, 3: text_bytes.push_back(letter());
                4: begin
                    // line comment, usually closed by a newline
                    text_bytes.push_back(cstrip_pkg::CH_SLASH);
                    text_bytes.push_back(cstrip_pkg::CH_SLASH);
                    n = $urandom_range(0, 5);
                    repeat (n) text_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                                    8'($urandom_range(1, 255)) : letter());
                    text_bytes.push_back(cstrip_pkg::CH_NL);
                end
                5: begin
                    // block comment; one in four left open
                    text_bytes.push_back(cstrip_pkg::CH_SLASH);
                    text_bytes.push_back(cstrip_pkg::CH_STAR);
                    n = $urandom_range(0, 6);
                    repeat (n) text_bytes.push_back(comment_char());
                    if ($urandom_range(0, 3) != 0) begin
                        text_bytes.push_back(cstrip_pkg::CH_STAR);
                        text_bytes.push_back(cstrip_pkg::CH_SLASH);
                    end
                end
                6: begin
                    // string with escapes
                    text_bytes.push_back(cstrip_pkg::CH_DQUOTE);
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0) begin
                            text_bytes.push_back(cstrip_pkg::CH_BSLASH);
                            case ($urandom_range(0, 2))
                                0:       text_bytes.push_back(cstrip_pkg::CH_DQUOTE);
                                1:       text_bytes.push_back(cstrip_pkg::CH_BSLASH);
                                default: text_bytes.push_back(letter());
                            endcase
                        end else begin
                            text_bytes.push_back(comment_char());
                        end
                    end
                    text_bytes.push_back(cstrip_pkg::CH_DQUOTE);
                end
                7: begin
                    text_bytes.push_back(cstrip_pkg::CH_SQUOTE);
                    if ($urandom_range(0, 1) == 0) text_bytes.push_back(cstrip_pkg::CH_BSLASH);
                    text_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                         cstrip_pkg::CH_SQUOTE : letter());
                    text_bytes.push_back(cstrip_pkg::CH_SQUOTE);
                end
                8: begin
                    // line splice, with or without CR
                    text_bytes.push_back(cstrip_pkg::CH_BSLASH);
                    if ($urandom_range(0, 1) == 0) text_bytes.push_back(cstrip_pkg::CH_CR);
                    text_bytes.push_back(cstrip_pkg::CH_NL);
                end
                9: begin
                    case ($urandom_range(0, 6))
                        0:       text_bytes.push_back(cstrip_pkg::CH_SLASH);
                        1:       text_bytes.push_back(cstrip_pkg::CH_BSLASH);
                        2:       text_bytes.push_back(cstrip_pkg::CH_CR);
                        3:       text_bytes.push_back(cstrip_pkg::CH_STAR);
                        4:       text_bytes.push_back(cstrip_pkg::CH_DQUOTE);
                        5:       text_bytes.push_back(cstrip_pkg::CH_SQUOTE);
                        default: text_bytes.push_back(cstrip_pkg::CH_NL);
                    endcase
                end
                default: text_bytes.push_back(cstrip_pkg::CH_NL);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: drives at the falling edge, sees acceptance at the rising edge
    // ------------------------------------------------------------------
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_req     = 0;
    int hold_left    = 0;

    task automatic send_byte(input cstrip_pkg::t_in_item it, input logic typed,
                             input cstrip_pkg::t_out_item want);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        // transaction accepted at this edge
        predict_item(it);
        if (typed) begin
            expected_clean_q.push_back(want);
        end else begin
            foreach (item_results[k]) expected_clean_q.push_back(item_results[k]);
        end
    endtask

    // sender goes quiet until the block has handed back everything
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_clean_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: random, or a long hold-off counted here
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    int mismatches = 0;

    always @(posedge i_clk) begin
        cstrip_pkg::t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_clean_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: expected none, got byte %02h v%b l%b d%b u%b",
                         $time, out_item.clean_byte, out_item.byte_valid,
                         out_item.run_last, out_item.text_done,
                         out_item.unterminated_comment);
            end else begin
                want = expected_clean_q.pop_front();
                if (out_item.clean_byte !== want.clean_byte ||
                    out_item.byte_valid !== want.byte_valid ||
                    out_item.run_last !== want.run_last ||
                    out_item.text_done !== want.text_done ||
                    out_item.unterminated_comment !== want.unterminated_comment) begin
                    mismatches++;
                    $display("%0t ns: expected byte %02h v%b l%b d%b u%b, got %02h v%b l%b d%b u%b",
                             $time, want.clean_byte, want.byte_valid, want.run_last,
                             want.text_done, want.unterminated_comment,
                             out_item.clean_byte, out_item.byte_valid, out_item.run_last,
                             out_item.text_done, out_item.unterminated_comment);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without a transaction on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** c_comment_stripper: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                    sent;
        cstrip_pkg::t_in_item  it;
        cstrip_pkg::t_out_item want;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed text, no idling
        foreach (directed_text[i]) begin
            it.source_byte = directed_text[i].ch;
            it.end_of_text = directed_text[i].eot;
            want = {directed_text[i].want_byte, directed_text[i].want_flags};
            send_byte(it, directed_text[i].typed, want);
        end
        drain_results();

        // random texts under each idle mix
        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct = GAP_PCT[phase];
            stall_pct    = STALL_PCT[phase];
            // receiver holds off while the sender keeps offering: backs up the queue
            if (phase == 0) hold_req = HOLD_OFF_CYCLES;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                build_text();
                foreach (text_bytes[k]) begin
                    it.source_byte = text_bytes[k];
                    it.end_of_text = (k == text_bytes.size() - 1);
                    send_byte(it, 1'b0, '0);
                end
                sent += text_bytes.size();
            end
            drain_results();
        end

        // watch a little longer for stray transactions
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_clean_q.size() == 0)
            $display("** c_comment_stripper: PASSED **");
        else
            $display("** c_comment_stripper: FAILED **");
        $finish;
    end

endmodule
